/* rtl/core/target_rate_limiter_mtf_core_defines.svh */
// ----------------------------------------------------------------------------
// Target rate limiter assertion macros
// Shared concurrent assertion forms; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef TARGET_RATE_LIMITER_MTF_CORE_DEFINES_SVH
`define TARGET_RATE_LIMITER_MTF_CORE_DEFINES_SVH

`ifndef SYNTH

// ante implies cons in the same cycle
`define TRLM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trlm: same-cycle check failed");

// ante implies cons in the next cycle
`define TRLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trlm: next-cycle check failed");

// expr holds at every edge outside reset
`define TRLM_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("trlm: invariant failed");

`else

`define TRLM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TRLM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define TRLM_ASSERT_ALWAYS(lbl, clk, rst, expr)

`endif

`endif

/* rtl/core/trlm_pkg.sv */
// ----------------------------------------------------------------------------
// Target rate limiter package
// Payload types, controller command bundle, register codes and the hash.
// ----------------------------------------------------------------------------
`default_nettype none

package trlm_pkg;

   localparam int LIST_DEPTH_DEF = 20;
   localparam int HASH_W         = 8;
   localparam int TIME_W         = 32;
   localparam int PERIOD_W       = 16;
   localparam int MAXT_W         = 5;
   localparam int ADDR_W         = 64;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_IDX_W      = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TARGETS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD      = 1'd1;

   // seconds added to the next-allowed time on a refusal
   localparam logic [TIME_W-1:0] PENALTY = 32'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] target_address;
      logic [TIME_W-1:0] now_seconds;
      logic              immune;
   } req_type;

   typedef struct packed {
      logic              exceeded;
      logic [TIME_W-1:0] wait_seconds;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic calc;
      logic commit;
   } ctl_cmd_type;

   // 8-bit target hash: ((addr >> 17) ^ (addr >> 9)) low byte
   function automatic logic [HASH_W-1:0] target_hash(input logic [ADDR_W-1:0] addr);
      target_hash = addr[24:17] ^ addr[16:9];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/trlm_ctrl.sv */
// ----------------------------------------------------------------------------
// Target rate limiter controller
// Sequences capture, compare/multiply and commit for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "target_rate_limiter_mtf_core_defines.svh"

module trlm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output trlm_pkg::ctl_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.calc     = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response slot
   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `TRLM_ASSERT_IMPL(a_commit_slot_free, clock, reset, cmd.commit, slot_free)
   `TRLM_ASSERT_NEXT(a_accept_to_calc, clock, reset, req_valid && req_ready, state_ff == ST_CALC)
   `TRLM_ASSERT_NEXT(a_commit_shows_rsp, clock, reset, cmd.commit, rsp_valid_ff)
   `TRLM_ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0({cmd.load_req, cmd.calc, cmd.commit}))

endmodule

`default_nettype wire

/* rtl/core/trlm_dp.sv */
// ----------------------------------------------------------------------------
// Target rate limiter datapath
// Config registers, move-to-front hash list, next-allowed time, response.
// ----------------------------------------------------------------------------
`default_nettype none

module trlm_dp #(
   parameter int LIST_DEPTH = trlm_pkg::LIST_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [trlm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [trlm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire trlm_pkg::req_type                 req_payload,
   input  wire trlm_pkg::ctl_cmd_type             cmd,
   output trlm_pkg::rsp_type                      rsp_payload
);

   localparam int LIM_W  = $clog2(LIST_DEPTH + 1);
   localparam int SPAN_W = LIM_W + trlm_pkg::PERIOD_W;
   localparam int TW     = trlm_pkg::TIME_W;
   localparam int HW     = trlm_pkg::HASH_W;

   // config
   logic [trlm_pkg::MAXT_W-1:0]   maxt_ff;
   logic [trlm_pkg::PERIOD_W-1:0] period_ff;

   // state
   logic [HW-1:0] list_ff [LIST_DEPTH];
   logic [HW-1:0] list_in [LIST_DEPTH];
   logic [TW-1:0] nat_ff, nat_in;

   // captured request
   logic [HW-1:0] hash_ff;
   logic [TW-1:0] now_ff;
   logic          immune_ff;

   // compare/multiply stage
   logic                  front_hit_ff, front_hit_in;
   logic [LIST_DEPTH-1:0] match_ff, match_in;
   logic [LIM_W-1:0]      lim_ff, lim_in;
   logic [SPAN_W-1:0]     span_ff, span_in;
   logic [SPAN_W-1:0]     back_ff, back_in;

   // commit decisions
   logic                  no_change, hit, refuse, insert, catch_up;
   logic [LIST_DEPTH-1:0] shift_en;
   logic [TW-1:0]         nat_pen, nat_base;
   trlm_pkg::rsp_type     rsp_ff, rsp_in;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         maxt_ff   <= '0;
         period_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            trlm_pkg::REG_MAX_TARGETS: maxt_ff   <= csr_wdata[trlm_pkg::MAXT_W-1:0];
            trlm_pkg::REG_PERIOD:      period_ff <= csr_wdata[trlm_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         hash_ff   <= trlm_pkg::target_hash(req_payload.target_address);
         now_ff    <= req_payload.now_seconds;
         immune_ff <= req_payload.immune;
      end
   end

   // parallel compare, clamp and products
   always_comb begin
      if (int'(maxt_ff) > LIST_DEPTH) begin
         lim_in = LIM_W'(LIST_DEPTH);
      end else begin
         lim_in = LIM_W'(maxt_ff);
      end
      front_hit_in = (list_ff[0] == hash_ff);
      match_in     = '0;
      for (int i = 1; i < LIST_DEPTH; i++) begin
         match_in[i] = (list_ff[i] == hash_ff) && (i < int'(lim_in));
      end
      span_in = SPAN_W'(lim_in) * SPAN_W'(period_ff);
      if (lim_in == '0) begin
         back_in = '0;
      end else begin
         back_in = SPAN_W'(lim_in - LIM_W'(1)) * SPAN_W'(period_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         front_hit_ff <= front_hit_in;
         match_ff     <= match_in;
         lim_ff       <= lim_in;
         span_ff      <= span_in;
         back_ff      <= back_in;
      end
   end

   // commit: classify the request
   always_comb begin
      no_change = immune_ff || front_hit_ff || (lim_ff == '0);
      hit       = !no_change && (|match_ff);
      refuse    = !no_change && !hit && (now_ff < nat_ff);
      insert    = !no_change && !hit && !refuse;
      catch_up  = {1'b0, now_ff} > ({1'b0, nat_ff} + (TW + 1)'(span_ff));
      nat_pen   = nat_ff + trlm_pkg::PENALTY;
      nat_base  = catch_up ? (now_ff - TW'(back_ff)) : nat_ff;
   end

   // shift enables: up to the first match on a hit, through the active part on insert
   always_comb begin
      shift_en = '0;
      for (int k = 1; k < LIST_DEPTH; k++) begin
         if (hit) begin
            shift_en[k] = !(|(match_ff & ({LIST_DEPTH{1'b1}} >> (LIST_DEPTH - k))));
         end else begin
            shift_en[k] = insert && (k < int'(lim_ff));
         end
      end
   end

   // next list, time and response
   always_comb begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
         list_in[k] = list_ff[k];
      end
      nat_in = nat_ff;
      if (hit || insert) begin
         list_in[0] = hash_ff;
         for (int k = 1; k < LIST_DEPTH; k++) begin
            if (shift_en[k]) begin
               list_in[k] = list_ff[k-1];
            end
         end
      end
      if (refuse) begin
         nat_in = nat_pen;
      end else if (insert) begin
         nat_in = nat_base + TW'(period_ff);
      end
      rsp_in.exceeded     = refuse;
      rsp_in.wait_seconds = refuse ? (nat_pen - now_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LIST_DEPTH; k++) begin
            list_ff[k] <= '0;
         end
         nat_ff <= '0;
      end else if (cmd.commit) begin
         for (int k = 0; k < LIST_DEPTH; k++) begin
            list_ff[k] <= list_in[k];
         end
         nat_ff <= nat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/target_rate_limiter_mtf_core.sv */
// ----------------------------------------------------------------------------
// Target rate limiter core
// Per-sender distinct-target limit over a move-to-front list of target hashes.
// ----------------------------------------------------------------------------
// Each request passes capture, list compare and period multiply, then commit;
//   the next is taken only after commit, which waits while a finished response
//   is not taken. The response is registered at commit.
// Reset: synchronous, clears the hash list, next-allowed time and config registers.
// A new request is taken while the previous response still waits.
`default_nettype none

module target_rate_limiter_mtf_core #(
   parameter int LIST_DEPTH = trlm_pkg::LIST_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire trlm_pkg::req_type                 req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output trlm_pkg::rsp_type                      rsp_payload,
   input  wire logic                              csr_wr_en,
   input  wire logic [trlm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [trlm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   trlm_pkg::ctl_cmd_type cmd;

   // sequencing
   trlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // list, time and response
   trlm_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* tb/sv/target_rate_limiter_mtf_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target rate limiter response checker
// Watches the request, response and register ports of the core and keeps
// its own copy of the hash list, next-allowed time and register values.
// Each accepted request yields one predicted verdict. Each accepted response
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module trlm_limit_checker #(
   parameter int LIST_DEPTH = trlm_pkg::LIST_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  trlm_pkg::req_type                   req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  trlm_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [trlm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [trlm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding
);
   import trlm_pkg::*;

   // shadow state of the limiter
   logic [HASH_W-1:0]   hash_list [LIST_DEPTH];
   logic [TIME_W-1:0]   next_ok_time;
   logic [MAXT_W-1:0]   cfg_max;
   logic [PERIOD_W-1:0] cfg_period;

   rsp_type pending_verdicts [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic log_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      if (mismatches < 50)
         $display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // move entries 0..pos-1 down one place and put h at the front
   task automatic move_to_front(input int pos, input logic [HASH_W-1:0] h);
      int k;
      for (k = pos; k > 0; k--) begin
         if (k < LIST_DEPTH)
            hash_list[k] = hash_list[k-1];
      end
      hash_list[0] = h;
   endtask

   // verdict for one request; updates the shadow state
   task automatic judge_request(input req_type r, output rsp_type v);
      logic [HASH_W-1:0] h;
      logic [TIME_W-1:0] now;
      int                lim;
      int                i;
      logic [63:0]       span;
      logic [63:0]       back_off;
      v   = '0;
      h   = r.target_address[24:17] ^ r.target_address[16:9];
      now = r.now_seconds;
      if (r.immune)
         return;
      if (hash_list[0] == h)
         return;
      lim = int'(cfg_max);
      if (lim == 0)
         return;
      if (lim > LIST_DEPTH)
         lim = LIST_DEPTH;
      // search the active part of the list past the front
      for (i = 1; i < lim; i++) begin
         if (hash_list[i] == h) begin
            move_to_front(i, h);
            return;
         end
      end
      // new target too early: penalty and wait
      if (now < next_ok_time) begin
         next_ok_time   = next_ok_time + PENALTY;
         v.exceeded     = 1'b1;
         v.wait_seconds = next_ok_time - now;
         return;
      end
      // catch up a lagging next-allowed time, then advance one period
      span = 64'(lim) * 64'(cfg_period);
      if ({32'd0, now} > {32'd0, next_ok_time} + span) begin
         back_off     = 64'(lim - 1) * 64'(cfg_period);
         next_ok_time = TIME_W'({32'd0, now} - back_off);
      end
      next_ok_time = next_ok_time + TIME_W'(cfg_period);
      move_to_front(lim - 1, h);
   endtask

   always @(posedge clock) begin
      rsp_type got_v;
      rsp_type want_v;
      rsp_type new_v;
      if (reset) begin
         foreach (hash_list[i]) hash_list[i] = '0;
         next_ok_time = '0;
         cfg_max      = '0;
         cfg_period   = '0;
         pending_verdicts.delete();
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               REG_MAX_TARGETS: cfg_max    = csr_wdata[MAXT_W-1:0];
               REG_PERIOD:      cfg_period = csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
         // response compare comes before the new request is queued
         if (rsp_valid && rsp_ready) begin
            got_v = rsp_payload;
            if (pending_verdicts.size() == 0) begin
               log_mismatch("response with no request pending", got_v.wait_seconds, 0);
            end else begin
               want_v = pending_verdicts.pop_front();
               if (got_v.exceeded !== want_v.exceeded)
                  log_mismatch("exceeded", 32'(got_v.exceeded), 32'(want_v.exceeded));
               if (got_v.wait_seconds !== want_v.wait_seconds)
                  log_mismatch("wait_seconds", got_v.wait_seconds, want_v.wait_seconds);
            end
         end
         if (req_valid && req_ready) begin
            judge_request(req_payload, new_v);
            pending_verdicts.push_back(new_v);
         end
      end
      outstanding = pending_verdicts.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target rate limiter core testbench
// Drives directed and random requests through the core across several
// limit and period settings, with random idling on both channels, a long
// response stall and a drained pause. The checker module predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import trlm_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 88;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int outstanding;
   int cycle_count   = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   bit steady        = 1'b0;

   // limit and period per random phase
   int max_plan    [NUM_PHASES] = '{0, 1, 2, 3, 5, 20, 31, 12, 20, 7};
   int period_plan [NUM_PHASES] = '{9, 0, 1, 4, 3, 65535, 2, 6, 1, 5};

   target_rate_limiter_mtf_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   trlm_limit_checker limit_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("target_rate_limiter_mtf_core verification failed");
         $finish;
      end
   end

   // response side: random stalls, long holds on demand
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = 100;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= 16);
      end
   end

   // request whose address hashes to h
   function automatic req_type request_for(input logic [HASH_W-1:0] h,
                                           input logic [TIME_W-1:0] now,
                                           input logic imm);
      req_type r;
      r.target_address        = {$urandom(), $urandom()};
      r.target_address[24:17] = h ^ r.target_address[16:9];
      r.now_seconds           = now;
      r.immune                = imm;
      return r;
   endfunction

   // offer one request and wait for it to be taken
   task automatic offer(input req_type r);
      @(negedge clock);
      if (!steady && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering until every response is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // drain, settle, then load both registers
   task automatic configure(input int max_t, input int period);
      logic [CSR_DATA_W-1:0] d;
      drain();
      repeat (4) @(negedge clock);
      d         = CSR_DATA_W'($urandom());
      d[MAXT_W-1:0] = max_t[MAXT_W-1:0];
      write_csr(REG_MAX_TARGETS, d);
      write_csr(REG_PERIOD, period[CSR_DATA_W-1:0]);
   endtask

   initial begin
      logic [HASH_W-1:0] pool [24];
      int                pool_n;
      int                p;
      int                n;
      int                i;
      logic [HASH_W-1:0] h;
      logic [TIME_W-1:0] now_s;
      logic [TIME_W-1:0] t;
      logic              imm;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // unlimited after reset; zero hash hits the cleared front entry
      offer('{target_address: '0, now_seconds: '0, immune: 1'b0});
      offer('{target_address: '1, now_seconds: '1, immune: 1'b1});
      offer(request_for(8'h5A, 32'hFFFF_FFFF, 1'b0));

      // small limit: admit, front hit, deeper hit, refusal, immune
      configure(3, 5);
      offer(request_for(8'h11, 32'd100, 1'b0));
      offer(request_for(8'h11, 32'd100, 1'b0));
      offer(request_for(8'h00, 32'd100, 1'b0));
      offer(request_for(8'h22, 32'd100, 1'b0));
      offer(request_for(8'h33, 32'd101, 1'b0));
      offer(request_for(8'h44, 32'd102, 1'b0));
      offer(request_for(8'h11, 32'd102, 1'b0));
      offer(request_for(8'h55, 32'd102, 1'b1));
      offer(request_for(8'h66, 32'd103, 1'b0));
      // catch-up after a long silence
      offer(request_for(8'h77, 32'd5000, 1'b0));
      // top of the time range: penalty and period advance wrap
      offer(request_for(8'h88, 32'hFFFF_FFFF, 1'b0));
      offer(request_for(8'h99, 32'hFFFF_FFFE, 1'b0));
      offer(request_for(8'hAA, 32'hFFFF_FFFE, 1'b0));
      offer(request_for(8'hBB, 32'hFFFF_FFFF, 1'b0));
      offer(request_for(8'hCC, 32'hFFFF_FFFF, 1'b0));
      offer(request_for(8'hDD, 32'd4, 1'b0));

      // random phases over a small pool of hashes so that hits occur
      now_s = 32'd10;
      for (p = 0; p < NUM_PHASES; p++) begin
         configure(max_plan[p], period_plan[p]);
         pool_n = $urandom_range(2, 24);
         for (i = 0; i < 24; i++) pool[i] = HASH_W'($urandom());
         if ($urandom_range(0, 3) == 0) pool[0] = '0;
         steady = (p == 6);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 3 && n == 20) hold_requests++;
            if (p == 5 && n == 40) drain();
            imm = ($urandom_range(0, 99) < 8);
            if ($urandom_range(0, 99) < 5)
               h = HASH_W'($urandom());
            else
               h = pool[$urandom_range(0, pool_n - 1)];
            if ($urandom_range(0, 99) < 3)
               now_s = now_s + $urandom_range(1000, 100000);
            else
               now_s = now_s + $urandom_range(0, 3);
            t = now_s;
            // state is untouched here, so any time value is safe
            if (imm || (max_plan[p] == 0 && $urandom_range(0, 1) == 1))
               t = $urandom();
            offer(request_for(h, t, imm));
         end
      end
      steady = 1'b0;

      drain();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("target_rate_limiter_mtf_core verification clean");
      end else begin
         $display("target_rate_limiter_mtf_core verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/trlm_pkg.sv
rtl/core/trlm_ctrl.sv
rtl/core/trlm_dp.sv
rtl/core/target_rate_limiter_mtf_core.sv
tb/sv/target_rate_limiter_mtf_core_checker.sv
tb/sv/tb.sv
